@@ hw/rtl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Types, constants and helpers for the quaternion to ZYX Euler converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int VEC_W      = 36;   // q30 vector components
   localparam int CORDIC_W   = 45;   // normalized cordic datapath
   localparam int NORM_TOP   = 41;   // normalized magnitude below 2^41
   localparam int ISQRT_W    = 61;   // radicand bits
   localparam int ROOT_W     = 31;   // root bits
   localparam int ISQRT_STEPS = 31;  // one root bit per stage
   localparam int ISQRT_LAT  = ISQRT_STEPS + 2;
   localparam int CORDIC_EXTRA_LAT = 6;
   localparam int TAB_LEN    = 24;

   localparam logic signed [VEC_W-1:0] ONE_Q30 = VEC_W'(64'd1 << 30);
   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
   localparam logic [15:0] PITCH_UP   = 16'h4000;
   localparam logic [15:0] PITCH_DOWN = 16'hC000;

   localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } q2e_req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               pitch_clamped;
   } q2e_rsp_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic [CORDIC_W-1:0]        m;
   } q2e_nvec_type;

   function automatic logic [VEC_W-1:0] mag(input logic signed [VEC_W-1:0] v);
      mag = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
   endfunction

   // shift left by k when the magnitude stays below 2^NORM_TOP
   function automatic q2e_nvec_type norm_shift(input q2e_nvec_type v, input int k);
      q2e_nvec_type r;
      r = v;
      if ((v.m >> (NORM_TOP - k)) == '0) begin
         r.x = v.x <<< k;
         r.y = v.y <<< k;
         r.m = v.m << k;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/q2e_front.sv @@
// ----------------------------------------------------------------------------
// q2e_front
// Products of the quaternion components, then the five q30 trig terms.
// ----------------------------------------------------------------------------
module q2e_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  q2e_pkg::q2e_req_type              in_quat,
   output logic                              out_valid,
   output logic signed [q2e_pkg::VEC_W-1:0]  out_sr,
   output logic signed [q2e_pkg::VEC_W-1:0]  out_cr,
   output logic signed [q2e_pkg::VEC_W-1:0]  out_sp,
   output logic signed [q2e_pkg::VEC_W-1:0]  out_sy,
   output logic signed [q2e_pkg::VEC_W-1:0]  out_cy
);
   import q2e_pkg::*;

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   logic signed [31:0] wx_in, yz_in, xx_in, yy_in, wy_in, zx_in, wz_in, xy_in, zz_in;
   logic               v1_ff, v2_ff;
   logic signed [VEC_W-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   logic signed [VEC_W-1:0] sr_in, cr_in, sp_in, sy_in, cy_in;

   always_comb begin
      wx_in = in_quat.quat_w * in_quat.quat_x;
      yz_in = in_quat.quat_y * in_quat.quat_z;
      xx_in = in_quat.quat_x * in_quat.quat_x;
      yy_in = in_quat.quat_y * in_quat.quat_y;
      wy_in = in_quat.quat_w * in_quat.quat_y;
      zx_in = in_quat.quat_z * in_quat.quat_x;
      wz_in = in_quat.quat_w * in_quat.quat_z;
      xy_in = in_quat.quat_x * in_quat.quat_y;
      zz_in = in_quat.quat_z * in_quat.quat_z;
   end

   always_comb begin
      sr_in = (VEC_W'(wx_ff) + VEC_W'(yz_ff)) <<< 1;
      cr_in = ONE_Q30 - ((VEC_W'(xx_ff) + VEC_W'(yy_ff)) <<< 1);
      sp_in = (VEC_W'(wy_ff) - VEC_W'(zx_ff)) <<< 1;
      sy_in = (VEC_W'(wz_ff) + VEC_W'(xy_ff)) <<< 1;
      cy_in = ONE_Q30 - ((VEC_W'(yy_ff) + VEC_W'(zz_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= wx_in; yz_ff <= yz_in; xx_ff <= xx_in;
         yy_ff <= yy_in; wy_ff <= wy_in; zx_ff <= zx_in;
         wz_ff <= wz_in; xy_ff <= xy_in; zz_ff <= zz_in;
         sr_ff <= sr_in; cr_ff <= cr_in; sp_ff <= sp_in;
         sy_ff <= sy_in; cy_ff <= cy_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_sr    = sr_ff;
   assign out_cr    = cr_ff;
   assign out_sp    = sp_ff;
   assign out_sy    = sy_ff;
   assign out_cy    = cy_ff;

endmodule

@@ hw/rtl/q2e_isqrt.sv @@
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pitch cosine: square of the sine, 1 - s^2, pipelined integer square root.
// ----------------------------------------------------------------------------
module q2e_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [q2e_pkg::VEC_W-1:0]  in_sp,
   output logic                              out_valid,
   output logic signed [q2e_pkg::VEC_W-1:0]  out_sp,
   output logic [q2e_pkg::ROOT_W-1:0]        out_root,
   output logic                              out_pos,
   output logic                              out_neg
);
   import q2e_pkg::*;

   localparam int N = ISQRT_STEPS;

   logic [VEC_W-1:0]        spa;
   logic [59:0]             sq_ff, sq_in;
   logic signed [VEC_W-1:0] sp0_ff;
   logic                    pos0_ff, neg0_ff, v0_ff;
   logic                    pos0_in, neg0_in;

   logic [ISQRT_W-1:0]      rv_ff  [0:N];
   logic [ISQRT_W-1:0]      rv_in  [0:N];
   logic [ISQRT_W:0]        rr_ff  [0:N];
   logic [ISQRT_W:0]        rr_in  [0:N];
   logic [ISQRT_W:0]        trial  [0:N-1];
   logic signed [VEC_W-1:0] sp_ff  [0:N];
   logic                    pos_ff [0:N];
   logic                    neg_ff [0:N];
   logic                    v_ff   [0:N];

   always_comb begin
      spa     = mag(in_sp);
      sq_in   = 60'(spa[29:0]) * 60'(spa[29:0]);
      pos0_in = in_sp >= ONE_Q30;
      neg0_in = in_sp <= -ONE_Q30;
   end

   always_comb begin
      rv_in[0] = (ISQRT_W'(1) << 60) - ISQRT_W'(sq_ff);
      rr_in[0] = '0;
      for (int k = 0; k < N; k++) begin
         trial[k] = rr_ff[k] + ((ISQRT_W+1)'(1) << (60 - 2 * k));
         if ({1'b0, rv_ff[k]} >= trial[k]) begin
            rv_in[k+1] = rv_ff[k] - trial[k][ISQRT_W-1:0];
            rr_in[k+1] = (rr_ff[k] >> 1) + ((ISQRT_W+1)'(1) << (60 - 2 * k));
         end else begin
            rv_in[k+1] = rv_ff[k];
            rr_in[k+1] = rr_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int k = 0; k <= N; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v0_ff   <= in_valid;
         v_ff[0] <= v0_ff;
         for (int k = 1; k <= N; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff     <= sq_in;
         sp0_ff    <= in_sp;
         pos0_ff   <= pos0_in;
         neg0_ff   <= neg0_in;
         sp_ff[0]  <= sp0_ff;
         pos_ff[0] <= pos0_ff;
         neg_ff[0] <= neg0_ff;
         for (int k = 0; k <= N; k++) begin
            rv_ff[k] <= rv_in[k];
            rr_ff[k] <= rr_in[k];
         end
         for (int k = 1; k <= N; k++) begin
            sp_ff[k]  <= sp_ff[k-1];
            pos_ff[k] <= pos_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_sp    = sp_ff[N];
   assign out_root  = rr_ff[N][ROOT_W-1:0];
   assign out_pos   = pos_ff[N];
   assign out_neg   = neg_ff[N];

endmodule

@@ hw/rtl/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined atan2: normalize, fold to right half plane, vectoring stages,
// round to binary angle.
// ----------------------------------------------------------------------------
module q2e_cordic #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [q2e_pkg::VEC_W-1:0]  in_y,
   input  logic signed [q2e_pkg::VEC_W-1:0]  in_x,
   output logic                              out_valid,
   output logic [15:0]                       out_angle
);
   import q2e_pkg::*;

   localparam int N = CORDIC_STAGES;

   logic [VEC_W-1:0]           mx, my;
   q2e_nvec_type               nrm_ff [0:3];
   q2e_nvec_type               nrm_in [0:3];
   logic                       nz_ff  [0:3];
   logic                       nv_ff  [0:3];
   logic                       nz_in;

   logic signed [CORDIC_W-1:0] cx_ff  [0:N];
   logic signed [CORDIC_W-1:0] cx_in  [0:N];
   logic signed [CORDIC_W-1:0] cy_ff  [0:N];
   logic signed [CORDIC_W-1:0] cy_in  [0:N];
   logic [31:0]                acc_ff [0:N];
   logic [31:0]                acc_in [0:N];
   logic                       cz_ff  [0:N];
   logic                       cv_ff  [0:N];

   logic [31:0]                acc_rnd;
   logic [ANGLE_BITS-1:0]      q;
   logic [15:0]                r;
   logic [15:0]                ang_ff, ang_in;
   logic                       ov_ff;

   always_comb begin
      mx          = mag(in_x);
      my          = mag(in_y);
      nrm_in[0].x = CORDIC_W'(in_x);
      nrm_in[0].y = CORDIC_W'(in_y);
      nrm_in[0].m = CORDIC_W'((mx > my) ? mx : my);
      nz_in       = (in_x == '0) && (in_y == '0);
      for (int j = 1; j <= 3; j++) begin
         nrm_in[j] = norm_shift(norm_shift(nrm_ff[j-1], 128 >> (2 * j)), 64 >> (2 * j));
      end
   end

   always_comb begin
      if (nrm_ff[3].x < 0) begin
         cx_in[0]  = -nrm_ff[3].x;
         cy_in[0]  = -nrm_ff[3].y;
         acc_in[0] = HALF_TURN;
      end else begin
         cx_in[0]  = nrm_ff[3].x;
         cy_in[0]  = nrm_ff[3].y;
         acc_in[0] = '0;
      end
      for (int i = 0; i < N; i++) begin
         if (cy_ff[i] > 0) begin
            cx_in[i+1]  = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1]  = cy_ff[i] - (cx_ff[i] >>> i);
            acc_in[i+1] = acc_ff[i] + ATAN_TAB[i];
         end else begin
            cx_in[i+1]  = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1]  = cy_ff[i] + (cx_ff[i] >>> i);
            acc_in[i+1] = acc_ff[i] - ATAN_TAB[i];
         end
      end
   end

   always_comb begin
      acc_rnd = acc_ff[N] + (32'd1 << (31 - ANGLE_BITS));
      q       = acc_rnd[31 -: ANGLE_BITS];
   end

   generate
      if (ANGLE_BITS > 16) begin : g_down
         localparam int SH = ANGLE_BITS - 16;
         logic [ANGLE_BITS-1:0] qr;
         always_comb begin
            qr = q + (ANGLE_BITS'(1) << (SH - 1));
            r  = qr[ANGLE_BITS-1:SH];
         end
      end else begin : g_up
         always_comb r = 16'(q) << (16 - ANGLE_BITS);
      end
   endgenerate

   assign ang_in = cz_ff[N] ? 16'd0 : r;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= 3; j++) nv_ff[j] <= 1'b0;
         for (int i = 0; i <= N; i++) cv_ff[i] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         nv_ff[0] <= in_valid;
         for (int j = 1; j <= 3; j++) nv_ff[j] <= nv_ff[j-1];
         cv_ff[0] <= nv_ff[3];
         for (int i = 1; i <= N; i++) cv_ff[i] <= cv_ff[i-1];
         ov_ff <= cv_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= 3; j++) nrm_ff[j] <= nrm_in[j];
         nz_ff[0] <= nz_in;
         for (int j = 1; j <= 3; j++) nz_ff[j] <= nz_ff[j-1];
         for (int i = 0; i <= N; i++) begin
            cx_ff[i]  <= cx_in[i];
            cy_ff[i]  <= cy_in[i];
            acc_ff[i] <= acc_in[i];
         end
         cz_ff[0] <= nz_ff[3];
         for (int i = 1; i <= N; i++) cz_ff[i] <= cz_ff[i-1];
         ang_ff <= ang_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_angle = ang_ff;

endmodule

@@ hw/rtl/q2e_delay.sv @@
// ----------------------------------------------------------------------------
// q2e_delay
// Stallable delay line that keeps side results aligned with the pitch path.
// ----------------------------------------------------------------------------
module q2e_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 33
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] data_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign out_data = data_ff[DEPTH-1];

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// ZYX roll, pitch, yaw in binary angle units from a Q1.15 quaternion.
//
//   port group   dir   payload        notes
//   req_*        in    q2e_req_type   quaternion x, y, z, w
//   rsp_*        out   q2e_rsp_type   roll, pitch, yaw, pitch clamp flag
//
// One request per cycle sustained while the response register can move on; the
// pipeline depth is set by the square-root pipeline (one root bit per stage) and
// the vectoring CORDIC (one iteration per stage).
// Synchronous reset clears the valid bits only.
// A stall holds every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  q2e_pkg::q2e_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output q2e_pkg::q2e_rsp_type  rsp_data
);
   import q2e_pkg::*;

   localparam int CORDIC_LAT = CORDIC_STAGES + CORDIC_EXTRA_LAT;

   logic                    en;
   logic                    f_valid, i_valid, p_valid;
   logic signed [VEC_W-1:0] sr, cr, sp, sy, cy, sp_d, root_x;
   logic [ROOT_W-1:0]       root;
   logic                    pos, neg;
   logic [15:0]             roll_ang, yaw_ang, p_ang;
   logic [31:0]             ry_d;
   logic [1:0]              clamp_d;

   logic                    rsp_valid_ff, rsp_valid_in;
   q2e_rsp_type             rsp_ff, rsp_in;

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   q2e_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid & req_ready),
      .in_quat(req_data), .out_valid(f_valid),
      .out_sr(sr), .out_cr(cr), .out_sp(sp), .out_sy(sy), .out_cy(cy)
   );

   q2e_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_valid),
      .in_y(sr), .in_x(cr), .out_valid(), .out_angle(roll_ang)
   );

   q2e_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_valid),
      .in_y(sy), .in_x(cy), .out_valid(), .out_angle(yaw_ang)
   );

   q2e_delay #(.WIDTH(32), .DEPTH(ISQRT_LAT)) u_ry_delay (
      .clock(clock), .en(en), .in_data({roll_ang, yaw_ang}), .out_data(ry_d)
   );

   q2e_isqrt u_isqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_valid), .in_sp(sp),
      .out_valid(i_valid), .out_sp(sp_d), .out_root(root),
      .out_pos(pos), .out_neg(neg)
   );

   assign root_x = signed'(VEC_W'(root));

   q2e_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .reset(reset), .en(en), .in_valid(i_valid),
      .in_y(sp_d), .in_x(root_x), .out_valid(p_valid), .out_angle(p_ang)
   );

   q2e_delay #(.WIDTH(2), .DEPTH(CORDIC_LAT)) u_clamp_delay (
      .clock(clock), .en(en), .in_data({pos, neg}), .out_data(clamp_d)
   );

   always_comb begin
      rsp_valid_in         = en ? p_valid : rsp_valid_ff;
      rsp_in.roll_angle    = ry_d[31:16];
      rsp_in.yaw_angle     = ry_d[15:0];
      rsp_in.pitch_clamped = clamp_d[1] | clamp_d[0];
      if (clamp_d[1]) begin
         rsp_in.pitch_angle = PITCH_UP;
      end else if (clamp_d[0]) begin
         rsp_in.pitch_angle = PITCH_DOWN;
      end else begin
         rsp_in.pitch_angle = p_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/tb_quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Self-checking bench for the quaternion to ZYX Euler angle converter.
// A queued driver offers requests with random gaps, the response side stalls at
// random and a monitor checks every response against an in-bench CORDIC angle predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
   import q2e_pkg::*;

   localparam int  LATENCY    = 2 + 33 + 16 + 6 + 1;
   localparam int  N_RANDOM   = 1750;
   localparam longint CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   q2e_req_type  req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   q2e_rsp_type  rsp_data;

   q2e_req_type  pending_reqs[$];
   q2e_rsp_type  expected_angles[$];
   int           error_count = 0;
   int           rsp_count = 0;
   int           clamp_count = 0;
   longint       cycle_count = 0;
   bit           stim_done = 1'b0;
   bit           req_taken = 1'b0;
   int           send_gap = 0;
   int           hold_off = 0;
   int           long_hold_left = 0;

   logic [31:0] atan_turn [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   quaternion_to_euler_angles dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] vector_angle(longint y, longint x);
      logic [31:0] acc;
      longint m, dx, dy;
      acc = 32'd0;
      if (x == 0 && y == 0) return 16'd0;
      m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
      while (m < (64'sd1 <<< 40)) begin
         x *= 2;
         y *= 2;
         m *= 2;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx;
            y -= dy;
            acc += atan_turn[i];
         end else begin
            x -= dx;
            y += dy;
            acc -= atan_turn[i];
         end
      end
      acc = acc + 32'h0000_8000;
      return acc[31:16];
   endfunction

   function automatic q2e_rsp_type euler_from_quat(q2e_req_type q);
      q2e_rsp_type r;
      longint qx, qy, qz, qw, sr, cr, sp, sy, cy, one;
      qx = q.quat_x;
      qy = q.quat_y;
      qz = q.quat_z;
      qw = q.quat_w;
      one = 64'sd1 <<< 30;
      sr = 2 * (qw * qx + qy * qz);
      cr = one - 2 * (qx * qx + qy * qy);
      sp = 2 * (qw * qy - qz * qx);
      sy = 2 * (qw * qz + qx * qy);
      cy = one - 2 * (qy * qy + qz * qz);
      r.pitch_clamped = 1'b0;
      if (sp >= one) begin
         r.pitch_angle = PITCH_UP;
         r.pitch_clamped = 1'b1;
      end else if (sp <= -one) begin
         r.pitch_angle = PITCH_DOWN;
         r.pitch_clamped = 1'b1;
      end else begin
         r.pitch_angle = vector_angle(sp, longint'(root_floor((64'd1 << 60) - sp * sp)));
      end
      r.roll_angle = vector_angle(sr, cr);
      r.yaw_angle = vector_angle(sy, cy);
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch response %0d %s: got %0d expected %0d", rsp_count, field, got, want);
      error_count++;
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_quat(int x, int y, int z, int w);
      q2e_req_type q;
      q.quat_x = 16'(x);
      q.quat_y = 16'(y);
      q.quat_z = 16'(z);
      q.quat_w = 16'(w);
      pending_reqs.push_back(q);
   endtask

   initial begin
      real ang, c, s;
      // directed: identity, zero, extremes, gimbal lock both ways, half turns
      add_quat(0, 0, 0, 32767);
      add_quat(0, 0, 0, 0);
      add_quat(-32768, -32768, -32768, -32768);
      add_quat(32767, 32767, 32767, 32767);
      add_quat(0, 23170, 0, 23170);
      add_quat(0, -23170, 0, 23170);
      add_quat(0, 23171, 0, 23171);
      add_quat(0, -23171, 0, 23171);
      add_quat(-23170, 23170, 23170, 23170);
      add_quat(32767, 0, 0, 0);
      add_quat(0, 0, 32767, 0);
      add_quat(0, 32767, 0, 0);
      add_quat(-32768, 0, 0, 0);
      add_quat(0, 0, -32768, 0);
      add_quat(16384, 0, 0, 0);
      add_quat(23170, 0, 0, 0);
      add_quat(0, 0, 23170, 0);
      add_quat(0, 0, 0, -32768);
      add_quat(1, -1, 1, -1);
      add_quat(32767, -32768, 32767, -32768);
      add_quat(0, 16384, 16384, 16384);
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            // near-unit quaternion
            ang = $urandom_range(0, 62831) / 10000.0;
            c = $cos(ang / 2.0) * 32767.0;
            s = $sin(ang / 2.0) * 32767.0;
            case ($urandom_range(0, 3))
               0: add_quat(int'(s), 0, 0, int'(c));
               1: add_quat(0, int'(s), 0, int'(c));
               2: add_quat(0, 0, int'(s), int'(c));
               default: add_quat(int'(s * 0.577), int'(s * 0.577), -int'(s * 0.577),
                                 int'(c));
            endcase
         end else begin
            add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
         end
      end
      stim_done = 1'b1;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // request handshake seen at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the offered request
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data <= pending_reqs[0];
            expected_angles.push_back(euler_from_quat(pending_reqs.pop_front()));
            req_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 2) == 0) ?
                        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern, with one long hold-off early on
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (cycle_count == 300) begin
         long_hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            hold_off <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(1, 3);
      end
   end

   // monitor
   always @(posedge clock) begin
      q2e_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_angles.size() == 0) begin
            $display("unexpected response %0d", rsp_count);
            error_count++;
         end else begin
            want = expected_angles.pop_front();
            if (rsp_data.roll_angle !== want.roll_angle)
               report_mismatch("roll", rsp_data.roll_angle, want.roll_angle);
            if (rsp_data.pitch_angle !== want.pitch_angle)
               report_mismatch("pitch", rsp_data.pitch_angle, want.pitch_angle);
            if (rsp_data.yaw_angle !== want.yaw_angle)
               report_mismatch("yaw", rsp_data.yaw_angle, want.yaw_angle);
            if (rsp_data.pitch_clamped !== want.pitch_clamped)
               report_mismatch("clamp", rsp_data.pitch_clamped, want.pitch_clamped);
            if (want.pitch_clamped) clamp_count++;
         end
         rsp_count++;
      end
   end

   initial begin
      wait (stim_done);
      wait (pending_reqs.size() == 0 && !req_valid);
      while (expected_angles.size() != 0 && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_angles.size());
         $display("status: fail");
      end else begin
         $display("converted %0d quaternions, %0d at gimbal lock, %0d errors",
                  rsp_count, clamp_count, error_count);
         if (error_count == 0 && expected_angles.size() == 0) begin
            $display("status: pass");
         end else begin
            $display("status: fail");
         end
      end
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT + LATENCY * 4) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

endmodule

@@ sim.f @@
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_front.sv
hw/rtl/q2e_isqrt.sv
hw/rtl/q2e_cordic.sv
hw/rtl/q2e_delay.sv
hw/rtl/quaternion_to_euler_angles.sv
tb/tb_quaternion_to_euler_angles.sv
